// ----- rtl/che_pkg.sv -----
// shared types and constants for the class histogram entropy block
package che_pkg;

	localparam int MODE_W = 2;
	localparam int LABEL_W = 2;
	localparam int CNT_W = 32;
	localparam int PROB_W = 17;
	localparam int ENT_W = 18;
	localparam int NCLS_W = 3;

	localparam int NUM_BINS = 4;
	localparam int COUNT_BITS = CNT_W;
	localparam int FRAC_BITS = 16;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_MERGE = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [LABEL_W-1:0] label;
		logic [CNT_W-1:0]   merge_count0;
		logic [CNT_W-1:0]   merge_count1;
		logic [CNT_W-1:0]   merge_count2;
		logic [CNT_W-1:0]   merge_count3;
		logic [CNT_W-1:0]   merge_total;
		logic [LABEL_W-1:0] query_class;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0]   total_samples;
		logic [LABEL_W-1:0] tallest_bin;
		logic [PROB_W-1:0]  class_probability;
		logic [ENT_W-1:0]   entropy_bits;
		logic               bad_label;
		logic               saturated;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_TALL,
		ST_QDIV,
		ST_DIV,
		ST_NORM,
		ST_LOG,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	// control from the sequencer into the arithmetic unit
	typedef struct packed {
		logic div_start;
		logic log_start;
	} au_ctl_t;

	typedef struct packed {
		logic div_done;
		logic log_done;
	} au_sts_t;

endpackage

// ----- rtl/che_divider.sv -----
// restoring divider, one quotient bit per cycle, saturates at one
module che_divider #(
	parameter int COUNT_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COUNT_BITS-1:0] num,
	input  logic [COUNT_BITS-1:0] den,
	output logic                  done,
	output logic [FRAC_BITS:0]    quot
);
	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam logic [CW-1:0] LAST = CW'(FRAC_BITS - 1);

	logic [COUNT_BITS:0]   rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [FRAC_BITS:0]    quot_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS+1:0] shl;

	assign shl = {rem_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (num >= den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= (num >= den) ? (FRAC_BITS+1)'(1) << FRAC_BITS : '0;
		end else if (busy_q) begin
			if (shl >= {2'b00, den_q}) begin
				rem_q  <= (COUNT_BITS+1)'(shl - {2'b00, den_q});
				quot_q <= {quot_q[FRAC_BITS-1:0], 1'b1};
			end else begin
				rem_q  <= shl[COUNT_BITS:0];
				quot_q <= {quot_q[FRAC_BITS-1:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- rtl/che_log_unit.sv -----
// p * -log2(p) by repeated squaring, one fraction bit per cycle
module che_log_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [FRAC_BITS:0]   p,
	output logic                 done,
	output logic [FRAC_BITS+1:0] term
);
	localparam int KW = $clog2(FRAC_BITS + 1);
	localparam int NW = KW + FRAC_BITS;
	localparam logic [KW-1:0] LAST = KW'(FRAC_BITS - 1);

	typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_MUL, L_OUT} lst_t;

	lst_t                  st_q;
	logic [FRAC_BITS-1:0]  p_q;
	logic [FRAC_BITS+1:0]  m_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic [KW-1:0]         k_q;
	logic [KW-1:0]         cnt_q;
	logic [FRAC_BITS+1:0]  term_q;
	logic [2*FRAC_BITS+3:0] sq;
	logic [FRAC_BITS+2:0]  msq;
	logic [NW-1:0]         nl;
	logic [FRAC_BITS+NW-1:0] prod;

	assign sq   = m_q * m_q;
	assign msq  = sq[2*FRAC_BITS+2:FRAC_BITS];
	assign nl   = {KW'(FRAC_BITS) - k_q, {FRAC_BITS{1'b0}}} - NW'(frac_q);
	assign prod = p_q * nl;

	// msb position, at most FRAC_BITS-1
	function automatic logic [KW-1:0] msb_pos(input logic [FRAC_BITS-1:0] v);
		logic [KW-1:0] r;
		r = '0;
		for (int i = 1; i < FRAC_BITS; i++) begin
			if (v[i]) r = KW'(i);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
		end else begin
			case (st_q)
				L_IDLE: if (start) st_q <= (p == '0 || p[FRAC_BITS]) ? L_OUT : L_NORM;
				L_NORM: st_q <= L_SQ;
				L_SQ: if (cnt_q == LAST) st_q <= L_MUL;
				L_MUL: st_q <= L_OUT;
				L_OUT: st_q <= L_IDLE;
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				p_q    <= p[FRAC_BITS-1:0];
				term_q <= '0;
				frac_q <= '0;
				cnt_q  <= '0;
			end
			L_NORM: begin
				k_q <= msb_pos(p_q);
				m_q <= (FRAC_BITS+2)'({2'b00, p_q} << (KW'(FRAC_BITS) - msb_pos(p_q)));
			end
			L_SQ: begin
				cnt_q <= cnt_q + 1'b1;
				if (msq[FRAC_BITS+1]) begin
					m_q    <= msq[FRAC_BITS+2:1];
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					m_q    <= msq[FRAC_BITS+1:0];
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
				end
			end
			L_MUL: term_q <= (FRAC_BITS+2)'(prod >> FRAC_BITS);
			default: ;
		endcase
	end

	assign done = (st_q == L_OUT);
	assign term = term_q;

endmodule

// ----- rtl/class_histogram_entropy.sv -----
// Histogram store with a sequencer driving a shared divider and log unit.
// A command is taken when start is high and busy is low; busy then stays high
// through the result strobe, which lasts one cycle and cannot be held off by
// the receiver. A command runs the update and then the tallest-bin scan over
// the bins in use, the query division, and for each bin in use a division and
// a log of up to 16 steps each, with their handoffs. When the total is zero,
// the command goes from the scan straight to the result strobe.
module class_histogram_entropy (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  che_pkg::cmd_t cmd,
	output logic          result_valid,
	output che_pkg::rsp_t result,
	input  logic          cfg_we,
	input  logic [che_pkg::NCLS_W-1:0] cfg_wdata
);
	localparam int NUM_BINS = che_pkg::NUM_BINS;
	localparam int COUNT_BITS = che_pkg::COUNT_BITS;
	localparam int FRAC_BITS = che_pkg::FRAC_BITS;
	localparam int BW = $clog2(NUM_BINS);
	localparam int NW = $clog2(NUM_BINS + 1);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	che_pkg::state_t st_q, st_d;
	logic [che_pkg::NCLS_W-1:0] ncls_q;
	logic [COUNT_BITS-1:0] bins_q [NUM_BINS];
	logic [COUNT_BITS-1:0] total_q;
	che_pkg::cmd_t cmd_q;
	logic [BW-1:0] idx_q;
	logic [BW-1:0] tall_q;
	logic [COUNT_BITS-1:0] maxc_q;
	logic [FRAC_BITS:0] prob_q;
	logic [FRAC_BITS+3:0] ent_q;
	logic bad_q, sat_q;
	logic [NW-1:0] n_eff;
	che_pkg::au_ctl_t ctl;
	che_pkg::au_sts_t sts;
	logic [FRAC_BITS:0] quot;
	logic [FRAC_BITS+1:0] term;
	logic [COUNT_BITS-1:0] addend;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS:0] sum;
	logic last_bin;
	logic [BW:0] lim;
	logic [FRAC_BITS+3:0] ent_lim;

	always_comb begin
		if (ncls_q == '0) n_eff = NW'(1);
		else if (32'(ncls_q) > NUM_BINS) n_eff = NW'(NUM_BINS);
		else n_eff = NW'(ncls_q);
	end

	always_comb begin
		lim = '0;
		for (int i = 0; i <= BW; i++) begin
			if ((1 << i) < int'(n_eff)) lim = (BW+1)'(i + 1);
		end
		ent_lim = (FRAC_BITS+4)'(lim) << FRAC_BITS;
	end

	assign last_bin = (NW'(idx_q) + 1'b1 >= n_eff);
	assign cur = bins_q[idx_q];

	// one saturating adder walks the bins during update; a second one updates the total at the last bin
	always_comb begin
		addend = '0;
		if (cmd_q.mode == che_pkg::MODE_MERGE) begin
			case (idx_q)
				BW'(0): addend = COUNT_BITS'(cmd_q.merge_count0);
				BW'(1): addend = COUNT_BITS'(cmd_q.merge_count1);
				default: begin
					if (idx_q == BW'(2)) addend = COUNT_BITS'(cmd_q.merge_count2);
					else if (idx_q == BW'(3)) addend = COUNT_BITS'(cmd_q.merge_count3);
				end
			endcase
		end else if (cmd_q.mode == che_pkg::MODE_ADD) begin
			addend = (BW'(cmd_q.label) == idx_q && !bad_q) ? COUNT_BITS'(1) : '0;
		end
		sum = {1'b0, bins_q[idx_q]} + {1'b0, addend};
	end

	logic [COUNT_BITS-1:0] tadd;
	logic [COUNT_BITS:0] tsum;
	always_comb begin
		tadd = '0;
		if (cmd_q.mode == che_pkg::MODE_MERGE) tadd = COUNT_BITS'(cmd_q.merge_total);
		else if (cmd_q.mode == che_pkg::MODE_ADD && !bad_q) tadd = COUNT_BITS'(1);
		tsum = {1'b0, total_q} + {1'b0, tadd};
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			che_pkg::ST_IDLE: if (start) st_d = che_pkg::ST_UPD;
			che_pkg::ST_UPD: if (last_bin) st_d = che_pkg::ST_TALL;
			che_pkg::ST_TALL: if (last_bin) begin
				st_d = (total_q == '0) ? che_pkg::ST_DONE : che_pkg::ST_QDIV;
			end
			che_pkg::ST_QDIV: if (sts.div_done) st_d = che_pkg::ST_DIV;
			che_pkg::ST_DIV: st_d = che_pkg::ST_NORM;
			che_pkg::ST_NORM: if (sts.div_done) st_d = che_pkg::ST_LOG;
			che_pkg::ST_LOG: if (sts.log_done) st_d = che_pkg::ST_ACC;
			che_pkg::ST_ACC: st_d = last_bin ? che_pkg::ST_MUL : che_pkg::ST_DIV;
			che_pkg::ST_MUL: st_d = che_pkg::ST_DONE;
			che_pkg::ST_DONE: st_d = che_pkg::ST_IDLE;
			default: st_d = che_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (st_q)
			che_pkg::ST_TALL: ctl.div_start = last_bin && total_q != '0;
			che_pkg::ST_DIV: ctl.div_start = 1'b1;
			che_pkg::ST_NORM: ctl.log_start = sts.div_done;
			default: ;
		endcase
	end

	logic [BW-1:0] qsel;
	assign qsel = BW'(cmd_q.query_class);
	logic [COUNT_BITS-1:0] div_num;
	assign div_num = (st_q == che_pkg::ST_TALL) ? bins_q[qsel] : bins_q[idx_q];

	che_divider #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.num(div_num), .den(total_q), .done(sts.div_done), .quot(quot)
	);

	che_log_unit #(.FRAC_BITS(FRAC_BITS)) u_log (
		.clk(clk), .arst_n(arst_n), .start(ctl.log_start), .p(quot),
		.done(sts.log_done), .term(term)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= che_pkg::ST_IDLE;
			ncls_q  <= che_pkg::NCLS_W'(4);
			total_q <= '0;
			for (int i = 0; i < NUM_BINS; i++) bins_q[i] <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) ncls_q <= cfg_wdata;
			if (st_q == che_pkg::ST_UPD) begin
				if (cmd_q.mode == che_pkg::MODE_CLEAR) begin
					bins_q[idx_q] <= '0;
					if (last_bin) begin
						total_q <= '0;
						for (int i = 0; i < NUM_BINS; i++) bins_q[i] <= '0;
					end
				end else begin
					bins_q[idx_q] <= (sum >= {1'b0, CMAX}) ? CMAX : sum[COUNT_BITS-1:0];
					if (last_bin) total_q <= (tsum >= {1'b0, CMAX}) ? CMAX : tsum[COUNT_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			che_pkg::ST_IDLE: begin
				cmd_q  <= cmd;
				idx_q  <= '0;
				sat_q  <= 1'b0;
				ent_q  <= '0;
				prob_q <= '0;
				bad_q  <= (cmd.mode == che_pkg::MODE_ADD) && (NW'(cmd.label) >= n_eff);
			end
			che_pkg::ST_UPD: begin
				if (cmd_q.mode != che_pkg::MODE_CLEAR) begin
					if (sum >= {1'b0, CMAX} && addend != '0) sat_q <= 1'b1;
					if (last_bin && tsum >= {1'b0, CMAX} && tadd != '0) sat_q <= 1'b1;
				end
				idx_q  <= last_bin ? '0 : idx_q + 1'b1;
				tall_q <= '0;
			end
			che_pkg::ST_TALL: begin
				if (idx_q == '0 || cur > maxc_q) begin
					maxc_q <= cur;
					tall_q <= idx_q;
				end
				idx_q <= last_bin ? '0 : idx_q + 1'b1;
			end
			che_pkg::ST_QDIV: if (sts.div_done) begin
				prob_q <= (NW'(qsel) < n_eff) ? quot : '0;
			end
			che_pkg::ST_ACC: begin
				ent_q <= ent_q + (FRAC_BITS+4)'(term);
				idx_q <= idx_q + 1'b1;
			end
			che_pkg::ST_MUL: if (ent_q > ent_lim) ent_q <= ent_lim;
			default: ;
		endcase
	end

	assign busy = (st_q != che_pkg::ST_IDLE);
	assign result_valid = (st_q == che_pkg::ST_DONE);
	always_comb begin
		result.total_samples     = che_pkg::CNT_W'(total_q);
		result.tallest_bin       = che_pkg::LABEL_W'(tall_q);
		result.class_probability = che_pkg::PROB_W'(prob_q);
		result.entropy_bits      = che_pkg::ENT_W'(ent_q);
		result.bad_label         = bad_q;
		result.saturated         = sat_q;
	end

	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside busy");
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("double strobe");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("command not taken");
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.div_start && ctl.log_start)) else $error("unit conflict");

endmodule
